[design/gic_pkg.sv]
// ----------------------------------------------------------------------------
// gic_pkg
// Shared types, constants and the sequencer microprogram for the gamepad
// input conditioner.
// ----------------------------------------------------------------------------
package gic_pkg;

	// Counter width default for the button classifier
	localparam int COUNT_BITS_DEF = 16;

	// Normalized full scale in Q1.14
	localparam int ONE_Q14 = 16384;

	// Quotient bits produced by the shared divider (quotient < ONE_Q14)
	localparam int DIV_STEPS = 14;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEAD_ZONE_SQ  = 3'd0,
		REG_RANGE_X       = 3'd1,
		REG_RANGE_Y       = 3'd2,
		REG_ACT_THRESHOLD = 3'd3,
		REG_TAP_LENGTH    = 3'd4,
		REG_DTAP_LENGTH   = 3'd5,
		REG_DPAD_ENABLE   = 3'd6,
		REG_STICK_ENABLE  = 3'd7
	} cfg_reg_t;

	// Register file contents
	typedef struct packed {
		logic [31:0] dead_zone_sq;
		logic [14:0] range_x;
		logic [14:0] range_y;
		logic [14:0] activation_threshold;
		logic [15:0] tap_length;
		logic [15:0] double_tap_length;
		logic        dpad_enable;
		logic        stick_enable;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		dead_zone_sq:         32'd0,
		range_x:              15'd25600,
		range_y:              15'd25600,
		activation_threshold: 15'd8192,
		tap_length:           16'd10,
		double_tap_length:    16'd10,
		dpad_enable:          1'b1,
		stick_enable:         1'b1
	};

	// Button A event codes
	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_PRESSED  = 3'd1,
		EV_TAP      = 3'd2,
		EV_DOUBLE   = 3'd3,
		EV_RELEASED = 3'd4
	} event_t;

	// Datapath operations
	typedef enum logic [3:0] {
		OP_NONE  = 4'd0,
		OP_LOAD  = 4'd1,
		OP_SQX   = 4'd2,
		OP_SQY   = 4'd3,
		OP_DZ    = 4'd4,
		OP_SETX  = 4'd5,
		OP_SETY  = 4'd6,
		OP_DIV   = 4'd7,
		OP_STX   = 4'd8,
		OP_STY   = 4'd9,
		OP_FIN   = 4'd10
	} op_t;

	// Sequencer jump kinds
	typedef enum logic [1:0] {
		J_NEXT = 2'd0,  // advance
		J_IN   = 2'd1,  // hold until a request is taken, then advance
		J_DIV  = 2'd2,  // go to target until the last divide step, then advance
		J_OUT  = 2'd3   // hold while the result register is blocked, else target
	} jmp_t;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	typedef struct packed {
		op_t   op;
		jmp_t  jmp;
		step_t target;
	} ctl_t;

	// Program step addresses
	localparam step_t S_IDLE = 4'd0;
	localparam step_t S_SQX  = 4'd1;
	localparam step_t S_SQY  = 4'd2;
	localparam step_t S_DZ   = 4'd3;
	localparam step_t S_SETX = 4'd4;
	localparam step_t S_DIVX = 4'd5;
	localparam step_t S_STX  = 4'd6;
	localparam step_t S_SETY = 4'd7;
	localparam step_t S_DIVY = 4'd8;
	localparam step_t S_STY  = 4'd9;
	localparam step_t S_FIN  = 4'd10;

	// Microprogram ROM
	function automatic ctl_t ucode_rom(input step_t step);
		ctl_t w;
		w = '{op: OP_NONE, jmp: J_NEXT, target: S_IDLE};
		unique case (step)
			S_IDLE:  w = '{op: OP_LOAD, jmp: J_IN,   target: S_IDLE};
			S_SQX:   w = '{op: OP_SQX,  jmp: J_NEXT, target: S_IDLE};
			S_SQY:   w = '{op: OP_SQY,  jmp: J_NEXT, target: S_IDLE};
			S_DZ:    w = '{op: OP_DZ,   jmp: J_NEXT, target: S_IDLE};
			S_SETX:  w = '{op: OP_SETX, jmp: J_NEXT, target: S_IDLE};
			S_DIVX:  w = '{op: OP_DIV,  jmp: J_DIV,  target: S_DIVX};
			S_STX:   w = '{op: OP_STX,  jmp: J_NEXT, target: S_IDLE};
			S_SETY:  w = '{op: OP_SETY, jmp: J_NEXT, target: S_IDLE};
			S_DIVY:  w = '{op: OP_DIV,  jmp: J_DIV,  target: S_DIVY};
			S_STY:   w = '{op: OP_STY,  jmp: J_NEXT, target: S_IDLE};
			S_FIN:   w = '{op: OP_FIN,  jmp: J_OUT,  target: S_IDLE};
			default: w = '{op: OP_NONE, jmp: J_NEXT, target: S_IDLE};
		endcase
		return w;
	endfunction

endpackage

[design/gic_ifs.sv]
// ----------------------------------------------------------------------------
// gic_ifs
// Handshake channels of the gamepad input conditioner: configuration
// writes, poll samples and conditioned results.
// ----------------------------------------------------------------------------
interface gic_cfg_if import gic_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

interface gic_sample_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] axis_x;
	logic signed [15:0] axis_y;
	logic signed [15:0] hat_x;
	logic signed [15:0] hat_y;
	logic [7:0]         button_bits;

	modport source (output valid, axis_x, axis_y, hat_x, hat_y, button_bits,
		input ready);
	modport sink   (input valid, axis_x, axis_y, hat_x, hat_y, button_bits,
		output ready);
endinterface

interface gic_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] stick_x_norm;
	logic signed [15:0] stick_y_norm;
	logic [7:0]         direction_mask;
	logic [7:0]         button_mask;
	logic [2:0]         event_code;
	logic [15:0]        hold_length;
	logic [15:0]        last_press_length;
	logic               dir_up;
	logic               dir_down;
	logic               dir_left;
	logic               dir_right;
	logic               fire_any;

	modport source (output valid, stick_x_norm, stick_y_norm, direction_mask,
		button_mask, event_code, hold_length, last_press_length, dir_up,
		dir_down, dir_left, dir_right, fire_any, input ready);
	modport sink   (input valid, stick_x_norm, stick_y_norm, direction_mask,
		button_mask, event_code, hold_length, last_press_length, dir_up,
		dir_down, dir_left, dir_right, fire_any, output ready);
endinterface

[design/gic_sequencer.sv]
// ----------------------------------------------------------------------------
// gic_sequencer
// Step counter and microprogram fetch; resolves conditional jumps.
// ----------------------------------------------------------------------------
module gic_sequencer import gic_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_fire,
	input  logic div_last,
	input  logic out_blocked,
	output ctl_t ctl
);

	step_t step_q;
	step_t step_d;

	// Fetch the control word of the current step
	assign ctl = ucode_rom(step_q);

	// Resolve the next step
	always_comb begin
		unique case (ctl.jmp)
			J_NEXT: step_d = step_q + step_t'(1);
			J_IN:   step_d = in_fire ? step_q + step_t'(1) : step_q;
			J_DIV:  step_d = div_last ? step_q + step_t'(1) : ctl.target;
			J_OUT:  step_d = out_blocked ? step_q : ctl.target;
			default: step_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

[design/gic_stick_path.sv]
// ----------------------------------------------------------------------------
// gic_stick_path
// Stick datapath: sample registers, squared magnitude, dead zone, shared
// restoring divider for normalization, and direction mask.
// ----------------------------------------------------------------------------
module gic_stick_path import gic_pkg::*; (
	input  logic               clk,
	input  ctl_t               ctl,
	input  logic               in_fire,
	input  cfg_t               cfg,
	input  logic signed [15:0] axis_x,
	input  logic signed [15:0] axis_y,
	input  logic signed [15:0] hat_x,
	input  logic signed [15:0] hat_y,
	input  logic [7:0]         button_bits,
	output logic               div_last,
	output logic signed [15:0] nx,
	output logic signed [15:0] ny,
	output logic [7:0]         dmask,
	output logic [7:0]         buttons
);

	logic signed [15:0] ax_q, ay_q;
	logic [3:0]         hat_q;
	logic [7:0]         btn_q;
	logic [31:0]        sq_q;
	logic [31:0]        mag_q;
	logic [14:0]        r_q;
	logic [14:0]        rem_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic               neg_q;
	logic               sat_q;
	logic signed [15:0] nx_q, ny_q;

	logic [14:0]        rx_eff, ry_eff, r_sel;
	logic signed [15:0] v_sel;
	logic signed [16:0] v17, r17, vc;
	logic [16:0]        m;
	logic               sat_d;
	logic [15:0]        t;
	logic               ge;
	logic [14:0]        qmag;
	logic signed [15:0] qs, qres;
	logic signed [16:0] thr17, nx17, ny17;
	logic signed [31:0] sqx, sqy;

	// A range written as zero acts as one
	assign rx_eff = (cfg.range_x == '0) ? 15'd1 : cfg.range_x;
	assign ry_eff = (cfg.range_y == '0) ? 15'd1 : cfg.range_y;

	// Squares of the axes
	assign sqx = ax_q * ax_q;
	assign sqy = ay_q * ay_q;

	// Cap the selected axis above at its range, split into sign and magnitude
	always_comb begin
		v_sel = (ctl.op == OP_SETY) ? ay_q : ax_q;
		r_sel = (ctl.op == OP_SETY) ? ry_eff : rx_eff;
		v17   = 17'(v_sel);
		r17   = signed'({2'b00, r_sel});
		vc    = (v17 > r17) ? r17 : v17;
		m     = vc[16] ? 17'(-vc) : 17'(vc);
		sat_d = m >= {2'b00, r_sel};
	end

	// One restoring divide step
	assign t  = {rem_q, 1'b0};
	assign ge = t >= {1'b0, r_q};
	assign div_last = (cnt_q == DIV_CNT_W'(1));

	// Signed quotient, pinned at full scale when the magnitude reaches range
	always_comb begin
		qmag = sat_q ? 15'(ONE_Q14) : {1'b0, quo_q};
		qs   = signed'({1'b0, qmag});
		qres = neg_q ? -qs : qs;
	end

	// Datapath registers driven by the control word
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_LOAD: begin
				if (in_fire) begin
					ax_q  <= axis_x;
					ay_q  <= axis_y;
					hat_q <= {hat_y > 0, hat_y < 0, hat_x > 0, hat_x < 0};
					btn_q <= button_bits;
				end
			end
			OP_SQX: begin
				sq_q <= 32'(sqx);
			end
			OP_SQY: begin
				mag_q <= sq_q + 32'(sqy);
			end
			OP_DZ: begin
				if (mag_q <= cfg.dead_zone_sq) begin
					ax_q <= '0;
					ay_q <= '0;
				end
			end
			OP_SETX, OP_SETY: begin
				r_q   <= r_sel;
				rem_q <= sat_d ? '0 : m[14:0];
				quo_q <= '0;
				cnt_q <= DIV_CNT_W'(DIV_STEPS);
				neg_q <= vc[16];
				sat_q <= sat_d;
			end
			OP_DIV: begin
				rem_q <= ge ? 15'(t - {1'b0, r_q}) : t[14:0];
				quo_q <= {quo_q[DIV_STEPS-2:0], ge};
				cnt_q <= cnt_q - DIV_CNT_W'(1);
			end
			OP_STX: begin
				nx_q <= qres;
			end
			OP_STY: begin
				ny_q <= qres;
			end
			OP_NONE, OP_FIN: begin
			end
			default: begin
			end
		endcase
	end

	// Direction mask from hat signs and thresholded stick levels
	always_comb begin
		thr17 = signed'({2'b00, cfg.activation_threshold});
		nx17  = 17'(nx_q);
		ny17  = 17'(ny_q);
		dmask = {nx17 > thr17, nx17 < -thr17, ny17 > thr17, ny17 < -thr17, hat_q};
	end

	assign nx      = nx_q;
	assign ny      = ny_q;
	assign buttons = btn_q;

endmodule

[design/gic_tap_classifier.sv]
// ----------------------------------------------------------------------------
// gic_tap_classifier
// Press, hold, tap and double-tap classifier on button A with saturating
// tick counters.
// ----------------------------------------------------------------------------
module gic_tap_classifier import gic_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic        a,
	input  cfg_t        cfg,
	output event_t      ev,
	output logic [15:0] hold_length,
	output logic [15:0] last_press_length
);

	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	logic                  prev_q, pend_q;
	logic [COUNT_BITS-1:0] press_q, wait_q, held_q, last_q;
	logic                  pend_d;
	logic [COUNT_BITS-1:0] press_d, wait_d, held_d, last_d, wait_inc, press_inc;

	assign wait_inc  = (wait_q == CMAX) ? CMAX : wait_q + 1'b1;
	assign press_inc = (press_q == CMAX) ? CMAX : press_q + 1'b1;

	// Age a pending tap first, else look at the edges of A
	always_comb begin
		pend_d  = pend_q;
		press_d = press_q;
		wait_d  = wait_q;
		held_d  = held_q;
		last_d  = last_q;
		ev      = EV_NONE;
		if (pend_q) begin
			wait_d = wait_inc;
		end
		if (pend_q && 32'(wait_inc) > 32'(cfg.double_tap_length)) begin
			pend_d = 1'b0;
			wait_d = '0;
			ev     = EV_TAP;
		end else if (a && !prev_q) begin
			press_d = '0;
			ev      = EV_PRESSED;
		end else if (a && prev_q) begin
			held_d  = press_q;
			press_d = press_inc;
		end else if (!a && prev_q) begin
			last_d = press_q;
			held_d = '0;
			if (32'(press_q) < 32'(cfg.tap_length)) begin
				if (pend_q) begin
					pend_d = 1'b0;
					wait_d = '0;
					ev     = EV_DOUBLE;
				end else begin
					pend_d = 1'b1;
				end
			end else begin
				ev = EV_RELEASED;
			end
		end
	end

	assign hold_length       = 16'(held_d);
	assign last_press_length = 16'(last_d);

	// Commit the classifier state once per poll
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b0;
			pend_q  <= 1'b0;
			press_q <= '0;
			wait_q  <= '0;
			held_q  <= '0;
			last_q  <= '0;
		end else if (step) begin
			prev_q  <= a;
			pend_q  <= pend_d;
			press_q <= press_d;
			wait_q  <= wait_d;
			held_q  <= held_d;
			last_q  <= last_d;
		end
	end

endmodule

[design/gamepad_input_conditioner_top.sv]
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_top
// Conditions one gamepad poll per request: stick dead zone and
// normalization, direction and button flags, and button A events.
//
//   channel  direction  accepted when            carries
//   cfg      in         cfg.valid & cfg.ready    index, data
//   sample   in         sample.valid & ready     stick, hat, buttons
//   result   out        result.valid & ready     normalized stick, flags, event
//
// A request occupies the block until its result is registered; the result turns
// valid and the sample side is ready again in the same cycle, so no new request
// is taken while one is in progress. The microprogram runs two 14-step passes
// through the one shared restoring divider plus nine single steps. A finished
// result waits in the output register while the next request is taken; the
// sequencer only holds at its last step while that register is full and unread.
// Reset restores the configuration, sequencer, output valid and classifier.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner_top import gic_pkg::*; #(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	gic_cfg_if.sink     cfg,
	gic_sample_if.sink  sample,
	gic_result_if.source result
);

	cfg_t   cfg_q;
	ctl_t   ctl;
	logic   in_fire;
	logic   div_last;
	logic   out_valid_q;
	logic   out_blocked;
	logic   fin_fire;
	logic signed [15:0] nx, ny;
	logic [7:0]  dmask, buttons;
	event_t      ev;
	logic [15:0] hold_len, last_len;
	logic        up_d, down_d, left_d, right_d;

	// Configuration writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_DEAD_ZONE_SQ:  cfg_q.dead_zone_sq         <= cfg.data;
				REG_RANGE_X:       cfg_q.range_x              <= cfg.data[14:0];
				REG_RANGE_Y:       cfg_q.range_y              <= cfg.data[14:0];
				REG_ACT_THRESHOLD: cfg_q.activation_threshold <= cfg.data[14:0];
				REG_TAP_LENGTH:    cfg_q.tap_length           <= cfg.data[15:0];
				REG_DTAP_LENGTH:   cfg_q.double_tap_length    <= cfg.data[15:0];
				REG_DPAD_ENABLE:   cfg_q.dpad_enable          <= cfg.data[0];
				REG_STICK_ENABLE:  cfg_q.stick_enable         <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	// Handshake controls
	assign sample.ready = (ctl.op == OP_LOAD);
	assign in_fire      = sample.valid && sample.ready;
	assign out_blocked  = out_valid_q && !result.ready;
	assign fin_fire     = (ctl.op == OP_FIN) && !out_blocked;

	gic_sequencer u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_fire     (in_fire),
		.div_last    (div_last),
		.out_blocked (out_blocked),
		.ctl         (ctl)
	);

	gic_stick_path u_stick (
		.clk         (clk),
		.ctl         (ctl),
		.in_fire     (in_fire),
		.cfg         (cfg_q),
		.axis_x      (sample.axis_x),
		.axis_y      (sample.axis_y),
		.hat_x       (sample.hat_x),
		.hat_y       (sample.hat_y),
		.button_bits (sample.button_bits),
		.div_last    (div_last),
		.nx          (nx),
		.ny          (ny),
		.dmask       (dmask),
		.buttons     (buttons)
	);

	gic_tap_classifier #(
		.COUNT_BITS (COUNT_BITS)
	) u_tap (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (fin_fire),
		.a                 (buttons[0]),
		.cfg               (cfg_q),
		.ev                (ev),
		.hold_length       (hold_len),
		.last_press_length (last_len)
	);

	// Gate the direction mask into the four flags
	assign up_d    = (cfg_q.dpad_enable && dmask[2]) || (cfg_q.stick_enable && dmask[4]);
	assign down_d  = (cfg_q.dpad_enable && dmask[3]) || (cfg_q.stick_enable && dmask[5]);
	assign left_d  = (cfg_q.dpad_enable && dmask[0]) || (cfg_q.stick_enable && dmask[6]);
	assign right_d = (cfg_q.dpad_enable && dmask[1]) || (cfg_q.stick_enable && dmask[7]);

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (fin_fire) begin
			result.stick_x_norm      <= nx;
			result.stick_y_norm      <= ny;
			result.direction_mask    <= dmask;
			result.button_mask       <= buttons;
			result.event_code        <= ev;
			result.hold_length       <= hold_len;
			result.last_press_length <= last_len;
			result.dir_up            <= up_d;
			result.dir_down          <= down_d;
			result.dir_left          <= left_d;
			result.dir_right         <= right_d;
			result.fire_any          <= |{buttons[7], buttons[3:0]};
		end
	end

	assign result.valid = out_valid_q;

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for gamepad_input_conditioner_top. A queue of polls,
// first a directed set and then button A press/release runs with random
// stick, hat and button content, feeds a clocked driver. Each taken poll is
// run through a local model of the conditioner and the monitor compares
// every returned result with the oldest prediction. Registers are rewritten
// between phases while the block is idle, including extreme and degenerate
// settings. Both handshake sides stall at random, and the receiver holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module testbench;
	import gic_pkg::*;

	typedef struct packed {
		logic signed [15:0] ax;
		logic signed [15:0] ay;
		logic signed [15:0] hx;
		logic signed [15:0] hy;
		logic [7:0]         btn;
	} poll_t;

	typedef struct packed {
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic [7:0]         dmask;
		logic [7:0]         bmask;
		event_t             ev;
		logic [15:0]        hold;
		logic [15:0]        last;
		logic               up;
		logic               down;
		logic               left;
		logic               right;
		logic               fire;
	} cond_t;

	logic clk;
	logic arst_n;

	gic_cfg_if    cfg_ch ();
	gic_sample_if poll_ch ();
	gic_result_if cond_ch ();

	gamepad_input_conditioner_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.sample (poll_ch),
		.result (cond_ch)
	);

	// Register shadow and classifier state of the local model
	cfg_t        cfg_shadow = CFG_RESET;
	logic        a_prev     = 1'b0;
	logic        tap_wait   = 1'b0;
	logic [15:0] press_cnt  = '0;
	logic [15:0] wait_cnt   = '0;
	logic [15:0] held_cnt   = '0;
	logic [15:0] last_len   = '0;

	poll_t poll_pending[$];
	cond_t cond_expected[$];
	poll_t cur_poll;
	bit    poll_busy = 1'b0;
	bit    calm      = 1'b0;
	bit    hold_req  = 1'b0;
	int    gap_left  = 0;
	int    stall_left = 0;
	int    hold_left = 0;
	int    bad_results = 0;
	int    results_seen = 0;

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run limit
	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic logic [15:0] count_up(input logic [15:0] c);
		return (c == 16'hFFFF) ? c : c + 16'd1;
	endfunction

	// Cap above at the range, scale into Q1.14 truncating toward zero, clamp
	function automatic longint norm_axis(input longint v, input logic [14:0] rng);
		longint r;
		longint q;
		r = (rng == 0) ? 1 : longint'(rng);
		if (v > r)
			v = r;
		if (v < 0)
			q = -((-v) * ONE_Q14 / r);
		else
			q = v * ONE_Q14 / r;
		if (q > ONE_Q14)
			q = ONE_Q14;
		if (q < -ONE_Q14)
			q = -ONE_Q14;
		return q;
	endfunction

	// Predict one result and advance the button A classifier
	function automatic cond_t condition_poll(input poll_t p);
		cond_t  c;
		longint ax;
		longint ay;
		longint nx;
		longint ny;
		longint thr;
		logic   a;
		ax  = p.ax;
		ay  = p.ay;
		thr = longint'(cfg_shadow.activation_threshold);
		a   = p.btn[0];
		if (ax * ax + ay * ay <= longint'(cfg_shadow.dead_zone_sq)) begin
			ax = 0;
			ay = 0;
		end
		nx = norm_axis(ax, cfg_shadow.range_x);
		ny = norm_axis(ay, cfg_shadow.range_y);

		c.dmask    = '0;
		c.dmask[0] = p.hx < 0;
		c.dmask[1] = p.hx > 0;
		c.dmask[2] = p.hy < 0;
		c.dmask[3] = p.hy > 0;
		c.dmask[4] = ny < -thr;
		c.dmask[5] = ny > thr;
		c.dmask[6] = nx < -thr;
		c.dmask[7] = nx > thr;
		c.up    = (cfg_shadow.dpad_enable && c.dmask[2]) ||
			(cfg_shadow.stick_enable && c.dmask[4]);
		c.down  = (cfg_shadow.dpad_enable && c.dmask[3]) ||
			(cfg_shadow.stick_enable && c.dmask[5]);
		c.left  = (cfg_shadow.dpad_enable && c.dmask[0]) ||
			(cfg_shadow.stick_enable && c.dmask[6]);
		c.right = (cfg_shadow.dpad_enable && c.dmask[1]) ||
			(cfg_shadow.stick_enable && c.dmask[7]);

		// Age a pending tap first; an expired tap masks the A edge this tick
		c.ev = EV_NONE;
		if (tap_wait)
			wait_cnt = count_up(wait_cnt);
		if (tap_wait && wait_cnt > cfg_shadow.double_tap_length) begin
			tap_wait = 1'b0;
			wait_cnt = '0;
			c.ev     = EV_TAP;
		end else if (a && !a_prev) begin
			press_cnt = '0;
			c.ev      = EV_PRESSED;
		end else if (a && a_prev) begin
			held_cnt  = press_cnt;
			press_cnt = count_up(press_cnt);
		end else if (!a && a_prev) begin
			last_len = press_cnt;
			held_cnt = '0;
			if (press_cnt < cfg_shadow.tap_length) begin
				if (tap_wait) begin
					tap_wait = 1'b0;
					wait_cnt = '0;
					c.ev     = EV_DOUBLE;
				end else begin
					tap_wait = 1'b1;
				end
			end else begin
				c.ev = EV_RELEASED;
			end
		end
		a_prev = a;

		c.nx    = nx[15:0];
		c.ny    = ny[15:0];
		c.bmask = p.btn;
		c.hold  = held_cnt;
		c.last  = last_len;
		c.fire  = |(p.btn & 8'h8F);
		return c;
	endfunction

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v[15:0];
	endfunction

	function automatic longint isqrt(input longint n);
		longint lo;
		longint hi;
		longint mid;
		lo = 0;
		hi = 65536;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			if (mid * mid <= n)
				lo = mid;
			else
				hi = mid;
		end
		return lo;
	endfunction

	// Stick sample biased toward the range, threshold and dead zone edges
	function automatic logic signed [15:0] pick_axis(input logic [14:0] rng);
		longint r;
		longint v;
		int     jit;
		r   = (rng == 0) ? 1 : longint'(rng);
		jit = int'($urandom_range(0, 4)) - 2;
		case ($urandom_range(0, 5))
			0: v = longint'($urandom_range(0, 65535)) - 32768;
			1: v = 0;
			2: v = r + jit;
			3: v = $urandom_range(0, 1) ? 32767 : -32768;
			4: v = longint'($urandom_range(0, 600)) - 300;
			default: v = longint'(cfg_shadow.activation_threshold) * r / ONE_Q14 + jit;
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		return clamp16(v);
	endfunction

	function automatic logic signed [15:0] pick_hat();
		case ($urandom_range(0, 3))
			0: return 16'sd0;
			1: return $urandom_range(0, 1) ? 16'sd1 : -16'sd1;
			2: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic add_poll(input longint ax, input longint ay, input longint hx,
			input longint hy, input logic [7:0] btn);
		poll_t p;
		p.ax  = ax[15:0];
		p.ay  = ay[15:0];
		p.hx  = hx[15:0];
		p.hy  = hy[15:0];
		p.btn = btn;
		poll_pending = {poll_pending, p};
	endtask

	// Queue polls as A press/release runs sized around the tap windows
	task automatic queue_polls(input int n);
		poll_t  p;
		int     i;
		int     run_left;
		longint lim;
		longint dz;
		longint root;
		longint m;
		longint rest;
		bit     a_lvl;
		run_left = 0;
		a_lvl    = 1'b1;
		for (i = 0; i < n; i++) begin
			if (run_left == 0) begin
				a_lvl = !a_lvl;
				if (a_lvl)
					lim = longint'(cfg_shadow.tap_length) + 2;
				else
					lim = longint'(cfg_shadow.double_tap_length) + 3;
				if (lim > 40)
					lim = 40;
				run_left = $urandom_range(1, 32'(lim));
				if (a_lvl && $urandom_range(0, 7) == 0)
					run_left = $urandom_range(1, 40);
			end
			run_left--;
			p.ax  = pick_axis(cfg_shadow.range_x);
			p.ay  = pick_axis(cfg_shadow.range_y);
			p.hx  = pick_hat();
			p.hy  = pick_hat();
			p.btn = {7'($urandom_range(0, 127)), a_lvl};
			if ($urandom_range(0, 9) == 0)
				p.btn[0] = 1'($urandom_range(0, 1));
			// Land on or next to the dead zone circle
			dz = cfg_shadow.dead_zone_sq;
			if (dz != 0 && $urandom_range(0, 5) == 0) begin
				root = isqrt(dz);
				if (root > 32767)
					root = 32767;
				m    = longint'($urandom_range(0, 32'(root)));
				rest = dz - m * m;
				p.ax = clamp16($urandom_range(0, 1) ? m : -m);
				m    = isqrt(rest) + int'($urandom_range(0, 2)) - 1;
				p.ay = clamp16($urandom_range(0, 1) ? m : -m);
			end
			poll_pending = {poll_pending, p};
		end
	endtask

	// Write one register and mirror it in the shadow
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		case (idx)
			REG_DEAD_ZONE_SQ:  cfg_shadow.dead_zone_sq         = val;
			REG_RANGE_X:       cfg_shadow.range_x              = val[14:0];
			REG_RANGE_Y:       cfg_shadow.range_y              = val[14:0];
			REG_ACT_THRESHOLD: cfg_shadow.activation_threshold = val[14:0];
			REG_TAP_LENGTH:    cfg_shadow.tap_length           = val[15:0];
			REG_DTAP_LENGTH:   cfg_shadow.double_tap_length    = val[15:0];
			REG_DPAD_ENABLE:   cfg_shadow.dpad_enable          = val[0];
			REG_STICK_ENABLE:  cfg_shadow.stick_enable         = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_config(input logic [31:0] dz, input logic [14:0] rx,
			input logic [14:0] ry, input logic [14:0] thr, input logic [15:0] tap,
			input logic [15:0] dtap, input logic dpad, input logic stick);
		write_reg(REG_DEAD_ZONE_SQ, dz);
		write_reg(REG_RANGE_X, 32'(rx));
		write_reg(REG_RANGE_Y, 32'(ry));
		write_reg(REG_ACT_THRESHOLD, 32'(thr));
		write_reg(REG_TAP_LENGTH, 32'(tap));
		write_reg(REG_DTAP_LENGTH, 32'(dtap));
		write_reg(REG_DPAD_ENABLE, 32'(dpad));
		write_reg(REG_STICK_ENABLE, 32'(stick));
	endtask

	// Hold until every queued poll is taken and every result has returned
	task automatic settle();
		while (poll_pending.size() != 0 || poll_busy || cond_expected.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Poll driver: present the next queued poll, with random gaps
	always @(negedge clk) begin
		if (!poll_busy) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (!calm && $urandom_range(0, 99) < 14) begin
				gap_left = $urandom_range(0, 44);
			end else if (poll_pending.size() != 0) begin
				cur_poll = poll_pending.pop_front();
				poll_ch.axis_x      <= cur_poll.ax;
				poll_ch.axis_y      <= cur_poll.ay;
				poll_ch.hat_x       <= cur_poll.hx;
				poll_ch.hat_y       <= cur_poll.hy;
				poll_ch.button_bits <= cur_poll.btn;
				poll_busy = 1'b1;
			end
		end
		poll_ch.valid <= poll_busy;
	end

	// Predict on every taken poll
	always @(posedge clk) begin
		if (arst_n && poll_ch.valid && poll_ch.ready) begin
			cond_expected = {cond_expected, condition_poll(cur_poll)};
			poll_busy = 1'b0;
		end
	end

	// Result receiver: random stalls plus one long hold-off on request
	always @(negedge clk) begin : result_sink
		logic rdy;
		if (hold_req) begin
			hold_req  = 1'b0;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rdy = 1'b0;
		end else if (!calm && $urandom_range(0, 99) < 3) begin
			stall_left = $urandom_range(0, 9);
			rdy = 1'b0;
		end else begin
			rdy = 1'b1;
		end
		cond_ch.ready <= rdy;
	end

	// Result monitor: compare against the oldest prediction
	always @(posedge clk) begin : result_check
		cond_t got;
		cond_t want;
		if (arst_n && cond_ch.valid && cond_ch.ready) begin
			results_seen++;
			got.nx    = cond_ch.stick_x_norm;
			got.ny    = cond_ch.stick_y_norm;
			got.dmask = cond_ch.direction_mask;
			got.bmask = cond_ch.button_mask;
			got.ev    = event_t'(cond_ch.event_code);
			got.hold  = cond_ch.hold_length;
			got.last  = cond_ch.last_press_length;
			got.up    = cond_ch.dir_up;
			got.down  = cond_ch.dir_down;
			got.left  = cond_ch.dir_left;
			got.right = cond_ch.dir_right;
			got.fire  = cond_ch.fire_any;
			if (cond_expected.size() == 0) begin
				bad_results++;
				if (bad_results <= 10)
					$display("result %0d arrived with no poll outstanding", results_seen);
			end else begin
				want = cond_expected.pop_front();
				if (got !== want) begin
					bad_results++;
					if (bad_results <= 10) begin
						$display("result %0d: expected x=%0d y=%0d dir=%h btn=%h ev=%0d",
							results_seen, want.nx, want.ny, want.dmask, want.bmask,
							want.ev, " hold=%0d last=%0d udlrf=%b%b%b%b%b",
							want.hold, want.last, want.up, want.down, want.left,
							want.right, want.fire);
						$display("result %0d: actual   x=%0d y=%0d dir=%h btn=%h ev=%0d",
							results_seen, got.nx, got.ny, got.dmask, got.bmask,
							got.ev, " hold=%0d last=%0d udlrf=%b%b%b%b%b",
							got.hold, got.last, got.up, got.down, got.left,
							got.right, got.fire);
					end
				end
			end
		end
	end

	// Phases of stimulus
	initial begin : stimulus
		int          ph;
		int unsigned m;
		logic [31:0] dz;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_DEAD_ZONE_SQ;
		cfg_ch.data         = '0;
		poll_ch.valid       = 1'b0;
		poll_ch.axis_x      = '0;
		poll_ch.axis_y      = '0;
		poll_ch.hat_x       = '0;
		poll_ch.hat_y       = '0;
		poll_ch.button_bits = '0;
		cond_ch.ready       = 1'b0;
		arst_n              = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: short tap windows so every event shows up quickly
		set_config(32'd0, 15'd25600, 15'd25600, 15'd8192, 16'd3, 16'd2, 1'b1, 1'b1);
		add_poll(0, 0, 0, 0, 8'h00);
		add_poll(32767, -32768, -32768, 32767, 8'h01);  // press
		add_poll(-32768, 32767, 32767, -32768, 8'h00);  // short release, tap pending
		add_poll(25600, -25600, 1, -1, 8'h03);          // second press
		add_poll(-25600, 25600, -1, 1, 8'h04);          // double tap
		add_poll(12800, -12800, 0, 0, 8'h09);           // level equal to threshold
		add_poll(12803, -12803, 0, 0, 8'h11);           // just over threshold
		add_poll(-12803, 12803, 0, 0, 8'h21);
		add_poll(-12800, 12800, 0, 0, 8'h41);
		add_poll(1, -1, 0, 0, 8'h80);                   // release at tap length
		add_poll(0, 0, 0, 0, 8'h81);
		add_poll(0, 0, 0, 0, 8'h01);
		add_poll(0, 0, 0, 0, 8'h00);                    // tap pending
		add_poll(256, 0, 0, 0, 8'hFE);
		add_poll(0, 256, 0, 0, 8'h00);
		add_poll(0, 0, 0, 0, 8'hFF);                    // tap expires, A edge masked
		add_poll(0, 0, 0, 0, 8'h00);
		add_poll(0, 0, 0, 0, 8'h70);                    // no fire buttons
		add_poll(0, 0, 0, 0, 8'h00);
		add_poll(0, 0, 0, 0, 8'h00);
		settle();

		// Power-on settings
		set_config(32'd0, 15'd25600, 15'd25600, 15'd8192, 16'd10, 16'd10, 1'b1, 1'b1);
		queue_polls(120);
		settle();

		// Low extremes
		set_config(32'd0, 15'd1, 15'd1, 15'd0, 16'd0, 16'd0, 1'b0, 1'b1);
		queue_polls(80);
		settle();

		// High extremes
		set_config(32'h8000_0000, 15'd32767, 15'd32767, 15'd16384, 16'hFFFF, 16'hFFFF,
			1'b1, 1'b0);
		queue_polls(60);
		settle();

		// Zero ranges, with a long receiver hold-off so the input backs up
		set_config(32'd10000, 15'd0, 15'd0, 15'($urandom_range(0, 16384)), 16'd4, 16'd3,
			1'b1, 1'b1);
		queue_polls(80);
		hold_req = 1'b1;
		settle();

		// Random settings; one phase runs without any stalls
		for (ph = 0; ph < 4; ph++) begin
			case ($urandom_range(0, 2))
				0: dz = 32'd0;
				1: begin
					m  = $urandom_range(0, 2000);
					dz = m * m;
				end
				default: begin
					m  = $urandom_range(0, 32767);
					dz = m * m;
				end
			endcase
			set_config(dz, 15'($urandom_range(1, 32767)), 15'($urandom_range(1, 32767)),
				15'($urandom_range(0, 16384)), 16'($urandom_range(0, 12)),
				16'($urandom_range(0, 12)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
			calm = (ph == 1);
			queue_polls(90);
			settle();
			calm = 1'b0;
		end

		// Drain and report
		repeat (40) @(posedge clk);
		if (bad_results == 0 && cond_expected.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[gamepad_input_conditioner_top.f]
design/gic_pkg.sv
design/gic_ifs.sv
design/gic_sequencer.sv
design/gic_stick_path.sv
design/gic_tap_classifier.sv
design/gamepad_input_conditioner_top.sv
test/testbench.sv
